/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; only the queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BSC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSC_ASSERT(name, clk, rst, prop, msg)
`define BSC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* rtl/bsc_pkg.sv */
// Shared types, constants and reciprocal table of the sensor compensation block.
package bsc_pkg;
   localparam int FRAC_BITS   = 24;
   localparam int RAW_W       = 24;
   localparam int SCALED_W    = 32;
   localparam int RECIP_W     = 31;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int OSR_W       = 3;
   localparam int TEMP_W      = 16;
   localparam int PRESS_W     = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_COEF_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_MIDDLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_LAST   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_OSR    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_OSR   = 3'd4;

   localparam logic [OSR_W-1:0] OSR_RESET = 3'd7;

   typedef struct packed {
      logic [11:0] c0;
      logic [11:0] c1;
      logic [19:0] c00;
      logic [19:0] c10;
      logic [15:0] c01;
      logic [15:0] c11;
      logic [15:0] c20;
      logic [15:0] c21;
      logic [15:0] c30;
   } coef_type;

   typedef struct packed {
      logic [SCALED_W-1:0] t;
      logic [SCALED_W-1:0] p;
   } scaled_type;

   // round(2^48 / k) for the eight oversampling scale factors
   function automatic logic [RECIP_W-1:0] recip(input logic [OSR_W-1:0] sel);
      logic [RECIP_W-1:0] r;
      unique case (sel)
         3'd0:    r = 31'd536870912;
         3'd1:    r = 31'd178956971;
         3'd2:    r = 31'd76695845;
         3'd3:    r = 31'd35791394;
         3'd4:    r = 31'd1108378657;
         3'd5:    r = 31'd545392673;
         3'd6:    r = 31'd270549121;
         3'd7:    r = 31'd134744072;
         default: r = 31'd134744072;
      endcase
      return r;
   endfunction
endpackage

/* rtl/bsc_ifs.sv */
// Handshake interfaces for the request, response and register channels.
interface bsc_req_if;
   logic valid;
   logic ready;
   logic signed [bsc_pkg::RAW_W-1:0] raw_temperature;
   logic signed [bsc_pkg::RAW_W-1:0] raw_pressure;
   modport source(output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink(input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bsc_rsp_if;
   logic valid;
   logic ready;
   logic signed [bsc_pkg::TEMP_W-1:0]  temperature_centi;
   logic signed [bsc_pkg::PRESS_W-1:0] pressure_pascal;
   logic saturated_flag;
   modport source(output valid, output temperature_centi, output pressure_pascal,
                  output saturated_flag, input ready);
   modport sink(input valid, input temperature_centi, input pressure_pascal,
                input saturated_flag, output ready);
endinterface

interface bsc_csr_if;
   logic valid;
   logic ready;
   logic [bsc_pkg::CSR_INDEX_W-1:0] index;
   logic [bsc_pkg::CSR_DATA_W-1:0]  data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/baro_sensor_compensation.sv */
// Top level of the barometric sensor compensation block.
// Takes one raw temperature/pressure pair per item and returns compensated
// temperature in hundredths of a degree and pressure in pascals, both
// truncated toward zero and clipped, with a flag when either was clipped.
// Calibration bytes and oversampling selects are loaded over the register
// channel; the user must load them only while no item is in flight, as the
// block does not enforce it. One item is accepted every cycle unless a full
// queue holds the front end; a result passes the front-end register, the
// queue and the six-register polynomial pipeline of the back end.
module baro_sensor_compensation (
   input  logic       clock,
   input  logic       reset,
   bsc_req_if.sink    req,
   bsc_rsp_if.source  rsp,
   bsc_csr_if.sink    csr
);
   logic [bsc_pkg::CSR_DATA_W-1:0] first_ff, middle_ff, last_ff;
   logic [bsc_pkg::OSR_W-1:0]      tosr_ff, posr_ff;
   logic                           csr_wr;
   bsc_pkg::coef_type              coef;
   logic signed [11:0]             c0_raw;
   logic                           push, full, pop, empty;
   bsc_pkg::scaled_type            push_data, head;

   assign csr.ready = 1'b1;
   assign csr_wr    = csr.valid && csr.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         middle_ff <= '0;
         last_ff   <= '0;
         tosr_ff   <= bsc_pkg::OSR_RESET;
         posr_ff   <= bsc_pkg::OSR_RESET;
      end else if (csr_wr) begin
         unique case (csr.index)
            bsc_pkg::REG_COEF_FIRST:  first_ff  <= csr.data;
            bsc_pkg::REG_COEF_MIDDLE: middle_ff <= csr.data;
            bsc_pkg::REG_COEF_LAST:   last_ff   <= csr.data;
            bsc_pkg::REG_TEMP_OSR:    tosr_ff   <= csr.data[bsc_pkg::OSR_W-1:0];
            bsc_pkg::REG_PRESS_OSR:   posr_ff   <= csr.data[bsc_pkg::OSR_W-1:0];
            default: ;
         endcase
      end
   end

   // c0 is halved toward zero
   assign c0_raw    = $signed(first_ff[47:36]);
   assign coef.c0   = 12'((c0_raw + $signed({11'd0, c0_raw[11]})) >>> 1);
   assign coef.c1   = first_ff[35:24];
   assign coef.c00  = first_ff[23:4];
   assign coef.c10  = {first_ff[3:0], middle_ff[47:32]};
   assign coef.c01  = middle_ff[31:16];
   assign coef.c11  = middle_ff[15:0];
   assign coef.c20  = last_ff[47:32];
   assign coef.c21  = last_ff[31:16];
   assign coef.c30  = last_ff[15:0];

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .temp_osr  (tosr_ff),
      .press_osr (posr_ff),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   bsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   bsc_back u_back (
      .clock (clock),
      .reset (reset),
      .coef  (coef),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );
endmodule

/* rtl/bsc_front.sv */
// Front end: accepts raw readings and scales them by reciprocal multiplication.
module bsc_front (
   input  logic                          clock,
   input  logic                          reset,
   bsc_req_if.sink                       req,
   input  logic [bsc_pkg::OSR_W-1:0]     temp_osr,
   input  logic [bsc_pkg::OSR_W-1:0]     press_osr,
   output logic                          push,
   output bsc_pkg::scaled_type           push_data,
   input  logic                          full
);
   localparam int PROD_W = bsc_pkg::RAW_W + bsc_pkg::RECIP_W;

   logic                      vld_ff, vld_in;
   logic [PROD_W-1:0]         tprod_ff, tprod_in, pprod_ff, pprod_in;
   logic                      tneg_ff, pneg_ff;
   logic [bsc_pkg::RAW_W-1:0] tmag, pmag;
   logic [PROD_W-bsc_pkg::FRAC_BITS-1:0] tq, pq;
   logic                      accept;

   assign req.ready = !vld_ff || !full;
   assign accept    = req.valid && req.ready;
   assign push      = vld_ff && !full;

   assign tmag = req.raw_temperature[bsc_pkg::RAW_W-1] ?
                 bsc_pkg::RAW_W'(-req.raw_temperature) : req.raw_temperature;
   assign pmag = req.raw_pressure[bsc_pkg::RAW_W-1] ?
                 bsc_pkg::RAW_W'(-req.raw_pressure) : req.raw_pressure;
   assign tprod_in = tmag * bsc_pkg::recip(temp_osr);
   assign pprod_in = pmag * bsc_pkg::recip(press_osr);

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tprod_ff <= tprod_in;
         pprod_ff <= pprod_in;
         tneg_ff  <= req.raw_temperature[bsc_pkg::RAW_W-1];
         pneg_ff  <= req.raw_pressure[bsc_pkg::RAW_W-1];
      end
   end

   // truncate toward zero: shift the magnitude, then restore the sign
   assign tq = tprod_ff[PROD_W-1:bsc_pkg::FRAC_BITS];
   assign pq = pprod_ff[PROD_W-1:bsc_pkg::FRAC_BITS];
   assign push_data.t = tneg_ff ? -{1'b0, tq} : {1'b0, tq};
   assign push_data.p = pneg_ff ? -{1'b0, pq} : {1'b0, pq};
endmodule

/* rtl/bsc_queue.sv */
// Short queue of scaled items between front and back end.
`include "assert_macros.svh"
module bsc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bsc_pkg::scaled_type push_data,
   output logic                full,
   input  logic                pop,
   output bsc_pkg::scaled_type head,
   output logic                empty
);
   bsc_pkg::scaled_type             mem_ff [bsc_pkg::QUEUE_DEPTH];
   logic [bsc_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [bsc_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;

   assign full  = (cnt_ff == bsc_pkg::QCNT_W'(bsc_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BSC_ASSERT(a_no_overflow, clock, reset, push |-> !full, "item pushed into full queue")
   `BSC_ASSERT(a_no_underflow, clock, reset, pop |-> !empty, "item popped from empty queue")
   `BSC_ASSERT(a_count_pop, clock, reset, (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 1'b1), "count did not drop on pop")
   `BSC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (empty && !full), "queue not empty after reset")
endmodule

/* rtl/bsc_back.sv */
// Back end: pipelined compensation polynomials and output saturation.
module bsc_back (
   input  logic                clock,
   input  logic                reset,
   input  bsc_pkg::coef_type   coef,
   input  bsc_pkg::scaled_type head,
   input  logic                empty,
   output logic                pop,
   bsc_rsp_if.source           rsp
);
   localparam int F = bsc_pkg::FRAC_BITS;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;

   // stage 1
   logic signed [31:0] ht, hp;
   logic [30:0]        tmag, pmag;
   logic signed [47:0] m_c30p, m_c21p, m_c01t;
   logic signed [45:0] m_c1t;
   logic [30:0]        s1_pmag_ff;
   logic               s1_psign_ff, s1_tpneg_ff;
   logic signed [47:0] s1_inner1_ff, s1_inner1_in, s1_inner3_ff, s1_inner3_in;
   logic [61:0]        s1_tp_ff, s1_tp_in;
   logic signed [45:0] s1_tv_ff, s1_tv_in;
   logic signed [47:0] s1_c01t_ff;

   // stage 2
   logic [46:0]        in1_mag, in3_mag;
   logic [37:0]        tpmag;
   logic [54:0]        s2_q1lo_ff, s2_q1lo_in;
   logic [53:0]        s2_q1hi_ff, s2_q1hi_in;
   logic [61:0]        s2_q3lo_ff, s2_q3lo_in;
   logic [60:0]        s2_q3hi_ff, s2_q3hi_in;
   logic               s2_q1neg_ff, s2_q3neg_ff;
   logic [30:0]        s2_pmag_ff;
   logic               s2_psign_ff;
   logic signed [47:0] s2_c01t_ff;
   logic signed [52:0] tv100, tv100_adj;
   logic signed [28:0] tq;
   logic [15:0]        s2_temp_ff, s2_temp_in;
   logic               s2_tsat_ff, s2_tsat_in;

   // stage 3
   logic [54:0]        q1;
   logic [60:0]        q3;
   logic signed [55:0] s3_inner2_ff, s3_inner2_in;
   logic signed [61:0] s3_tterm_ff, s3_tterm_in;
   logic [30:0]        s3_pmag_ff;
   logic               s3_psign_ff;
   logic signed [47:0] s3_c01t_ff;
   logic [15:0]        s3_temp_ff;
   logic               s3_tsat_ff;

   // stage 4
   logic [54:0]        in2_mag;
   logic [58:0]        s4_q2lo_ff, s4_q2lo_in;
   logic [57:0]        s4_q2hi_ff, s4_q2hi_in;
   logic               s4_q2neg_ff;
   logic signed [62:0] s4_rest_ff, s4_rest_in;
   logic [15:0]        s4_temp_ff;
   logic               s4_tsat_ff;

   // stage 5
   logic [61:0]        q2;
   logic signed [62:0] s5_pv_ff, s5_pv_in;
   logic [15:0]        s5_temp_ff;
   logic               s5_tsat_ff;

   // output
   logic signed [62:0] pv_adj;
   logic signed [38:0] pq;
   logic [23:0]        o_press_in, o_press_ff;
   logic               o_psat;
   logic [15:0]        o_temp_ff;
   logic               o_sat_ff;

   assign en  = !vo_ff || rsp.ready;
   assign pop = en && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= !empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vo_ff <= v5_ff;
      end
   end

   // stage 1: coefficient products and the temperature product
   assign ht   = $signed(head.t);
   assign hp   = $signed(head.p);
   assign tmag = ht[31] ? 31'(-ht) : ht[30:0];
   assign pmag = hp[31] ? 31'(-hp) : hp[30:0];
   assign m_c30p = $signed(coef.c30) * hp;
   assign m_c21p = $signed(coef.c21) * hp;
   assign m_c01t = $signed(coef.c01) * ht;
   assign m_c1t  = $signed(coef.c1) * ht;
   assign s1_inner1_in = m_c30p + (48'($signed(coef.c20)) <<< F);
   assign s1_inner3_in = m_c21p + (48'($signed(coef.c11)) <<< F);
   assign s1_tp_in     = tmag * pmag;
   assign s1_tv_in     = m_c1t + (46'($signed(coef.c0)) <<< F);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pmag_ff   <= pmag;
         s1_psign_ff  <= hp[31];
         s1_tpneg_ff  <= ht[31] ^ hp[31];
         s1_inner1_ff <= s1_inner1_in;
         s1_inner3_ff <= s1_inner3_in;
         s1_tp_ff     <= s1_tp_in;
         s1_tv_ff     <= s1_tv_in;
         s1_c01t_ff   <= m_c01t;
      end
   end

   // stage 2: split products, temperature output
   assign in1_mag = s1_inner1_ff[47] ? 47'(-s1_inner1_ff) : s1_inner1_ff[46:0];
   assign in3_mag = s1_inner3_ff[47] ? 47'(-s1_inner3_ff) : s1_inner3_ff[46:0];
   assign tpmag   = s1_tp_ff[61:F];
   assign s2_q1lo_in = s1_pmag_ff * in1_mag[F-1:0];
   assign s2_q1hi_in = s1_pmag_ff * in1_mag[46:F];
   assign s2_q3lo_in = tpmag * in3_mag[F-1:0];
   assign s2_q3hi_in = tpmag * in3_mag[46:F];

   assign tv100     = s1_tv_ff * 53'sd100;
   assign tv100_adj = tv100 + (tv100[52] ? $signed(53'({F{1'b1}})) : 53'sd0);
   assign tq        = tv100_adj[52:F];
   always_comb begin
      s2_tsat_in = (tq[28:15] != {14{tq[28]}});
      s2_temp_in = tq[15:0];
      if (s2_tsat_in) begin
         s2_temp_in = tq[28] ? 16'h8000 : 16'h7FFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_q1lo_ff  <= s2_q1lo_in;
         s2_q1hi_ff  <= s2_q1hi_in;
         s2_q3lo_ff  <= s2_q3lo_in;
         s2_q3hi_ff  <= s2_q3hi_in;
         s2_q1neg_ff <= s1_psign_ff ^ s1_inner1_ff[47];
         s2_q3neg_ff <= s1_tpneg_ff ^ s1_inner3_ff[47];
         s2_pmag_ff  <= s1_pmag_ff;
         s2_psign_ff <= s1_psign_ff;
         s2_c01t_ff  <= s1_c01t_ff;
         s2_temp_ff  <= s2_temp_in;
         s2_tsat_ff  <= s2_tsat_in;
      end
   end

   // stage 3: recombine, second inner term
   assign q1 = s2_q1hi_ff + s2_q1lo_ff[54:F];
   assign q3 = s2_q3hi_ff + s2_q3lo_ff[61:F];
   assign s3_inner2_in = (s2_q1neg_ff ? -$signed({1'b0, q1}) : $signed({1'b0, q1}))
                         + (56'($signed(coef.c10)) <<< F);
   assign s3_tterm_in  = s2_q3neg_ff ? -$signed({1'b0, q3}) : $signed({1'b0, q3});

   always_ff @(posedge clock) begin
      if (en) begin
         s3_inner2_ff <= s3_inner2_in;
         s3_tterm_ff  <= s3_tterm_in;
         s3_pmag_ff   <= s2_pmag_ff;
         s3_psign_ff  <= s2_psign_ff;
         s3_c01t_ff   <= s2_c01t_ff;
         s3_temp_ff   <= s2_temp_ff;
         s3_tsat_ff   <= s2_tsat_ff;
      end
   end

   // stage 4: last pressure product; constant, linear and temperature-pressure terms
   assign in2_mag    = s3_inner2_ff[55] ? 55'(-s3_inner2_ff) : s3_inner2_ff[54:0];
   assign s4_q2lo_in = s3_pmag_ff * in2_mag[27:0];
   assign s4_q2hi_in = s3_pmag_ff * in2_mag[54:28];
   assign s4_rest_in = (63'($signed(coef.c00)) <<< F) + 63'(s3_c01t_ff) + 63'(s3_tterm_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s4_q2lo_ff  <= s4_q2lo_in;
         s4_q2hi_ff  <= s4_q2hi_in;
         s4_q2neg_ff <= s3_psign_ff ^ s3_inner2_ff[55];
         s4_rest_ff  <= s4_rest_in;
         s4_temp_ff  <= s3_temp_ff;
         s4_tsat_ff  <= s3_tsat_ff;
      end
   end

   // stage 5: pressure sum
   assign q2 = {s4_q2hi_ff, 4'b0} + 62'(s4_q2lo_ff[58:F]);
   assign s5_pv_in = s4_rest_ff +
                     (s4_q2neg_ff ? -$signed({1'b0, q2}) : $signed({1'b0, q2}));

   always_ff @(posedge clock) begin
      if (en) begin
         s5_pv_ff   <= s5_pv_in;
         s5_temp_ff <= s4_temp_ff;
         s5_tsat_ff <= s4_tsat_ff;
      end
   end

   // output register: pressure truncation and clipping
   assign pv_adj = s5_pv_ff + (s5_pv_ff[62] ? $signed(63'({F{1'b1}})) : 63'sd0);
   assign pq     = pv_adj[62:F];
   always_comb begin
      o_psat     = (pq[38:23] != {16{pq[38]}});
      o_press_in = pq[23:0];
      if (o_psat) begin
         o_press_in = pq[38] ? 24'h800000 : 24'h7FFFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_temp_ff  <= s5_temp_ff;
         o_press_ff <= o_press_in;
         o_sat_ff   <= s5_tsat_ff | o_psat;
      end
   end

   assign rsp.valid             = vo_ff;
   assign rsp.temperature_centi = o_temp_ff;
   assign rsp.pressure_pascal   = o_press_ff;
   assign rsp.saturated_flag    = o_sat_ff;
endmodule
